[rtl/assert_macros.svh]
// Assertion macros for the RTL; used by c_source_char_metrics_core.
// Depends on nothing; take in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every rising edge of clk outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Never see cond at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/cslm_pkg.sv]
// Types and constants for the C source character metrics core.
// Depends on nothing; used by cslm_lexer and c_source_char_metrics_core.
package cslm_pkg;

    typedef enum logic [3:0] {
        LEX_NORMAL     = 4'd0,
        LEX_CHAR       = 4'd1,
        LEX_STRING     = 4'd2,
        LEX_CHR_ESC    = 4'd3,
        LEX_STR_ESC    = 4'd4,
        LEX_SLASH      = 4'd5,
        LEX_LINE_CMT   = 4'd6,
        LEX_BLOCK_CMT  = 4'd7,
        LEX_BLOCK_STAR = 4'd8
    } lex_state_t;

    localparam logic CMD_CHAR  = 1'b0;
    localparam logic CMD_IDENT = 1'b1;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    localparam int ID_LEN_WIDTH   = 10;
    localparam int LINE_LEN_WIDTH = 16;
    localparam int OUT_WIDTH      = 32;

    typedef struct packed {
        logic space_inc;
        logic string_inc;
        logic line_cmt_inc;
        logic block_cmt_inc;
        logic cmt_char_inc;
        logic cmt_char_dec;
    } lex_flags_t;

endpackage

[rtl/cslm_lexer.sv]
// Lexer step of the metrics core: next lexer state and counter events for one character.
// Depends on cslm_pkg.
module cslm_lexer (
    input  cslm_pkg::lex_state_t state,
    input  logic [7:0]           char_code,
    output cslm_pkg::lex_state_t state_next,
    output cslm_pkg::lex_flags_t flags
);

    logic is_space;

    assign is_space = (char_code == cslm_pkg::CH_SPACE) ||
                      ((char_code >= cslm_pkg::CH_TAB) && (char_code <= cslm_pkg::CH_CR));

    always_comb begin
        state_next = state;
        flags      = '0;
        unique case (state)
            cslm_pkg::LEX_CHAR: begin
                if (char_code == cslm_pkg::CH_QUOTE) begin
                    state_next = cslm_pkg::LEX_NORMAL;
                end else if (char_code == cslm_pkg::CH_BSLASH) begin
                    state_next = cslm_pkg::LEX_CHR_ESC;
                end
            end
            cslm_pkg::LEX_STRING: begin
                if (char_code == cslm_pkg::CH_DQUOTE) begin
                    state_next = cslm_pkg::LEX_NORMAL;
                end else if (char_code == cslm_pkg::CH_BSLASH) begin
                    state_next = cslm_pkg::LEX_STR_ESC;
                end
            end
            cslm_pkg::LEX_CHR_ESC: begin
                state_next = cslm_pkg::LEX_CHAR;
            end
            cslm_pkg::LEX_STR_ESC: begin
                state_next = cslm_pkg::LEX_STRING;
            end
            cslm_pkg::LEX_SLASH: begin
                if (char_code == cslm_pkg::CH_SLASH) begin
                    state_next         = cslm_pkg::LEX_LINE_CMT;
                    flags.line_cmt_inc = 1'b1;
                end else if (char_code == cslm_pkg::CH_STAR) begin
                    state_next          = cslm_pkg::LEX_BLOCK_CMT;
                    flags.block_cmt_inc = 1'b1;
                end else begin
                    state_next = cslm_pkg::LEX_NORMAL;
                end
            end
            cslm_pkg::LEX_LINE_CMT: begin
                if (char_code == cslm_pkg::CH_NL) begin
                    state_next = cslm_pkg::LEX_NORMAL;
                end else begin
                    flags.cmt_char_inc = 1'b1;
                end
            end
            cslm_pkg::LEX_BLOCK_CMT: begin
                if (char_code == cslm_pkg::CH_STAR) begin
                    state_next = cslm_pkg::LEX_BLOCK_STAR;
                end
                flags.cmt_char_inc = 1'b1;
            end
            cslm_pkg::LEX_BLOCK_STAR: begin
                if (char_code == cslm_pkg::CH_SLASH) begin
                    state_next         = cslm_pkg::LEX_NORMAL;
                    flags.cmt_char_dec = 1'b1;
                end else begin
                    if (char_code != cslm_pkg::CH_STAR) begin
                        state_next = cslm_pkg::LEX_BLOCK_CMT;
                    end
                    flags.cmt_char_inc = 1'b1;
                end
            end
            default: begin
                state_next = cslm_pkg::LEX_NORMAL;
                if (is_space) begin
                    flags.space_inc = 1'b1;
                end else if (char_code == cslm_pkg::CH_SLASH) begin
                    state_next = cslm_pkg::LEX_SLASH;
                end else if (char_code == cslm_pkg::CH_QUOTE) begin
                    state_next = cslm_pkg::LEX_CHAR;
                end else if (char_code == cslm_pkg::CH_DQUOTE) begin
                    state_next       = cslm_pkg::LEX_STRING;
                    flags.string_inc = 1'b1;
                end
            end
        endcase
    end

endmodule

[rtl/c_source_char_metrics_core.sv]
// Top level of the C source character metrics core: input register, counters, result.
// Depends on cslm_pkg, cslm_lexer and assert_macros.svh.
//
// Takes one item per cycle as long as m_ready is high. A transfer on the s_ side lands in an
// input register; the lexer step and the saturating counter updates then run on it, and the
// counters, which double as the result register, present the new metrics on the m_ side;
// m_valid rises when the counters load. Counters are COUNT_WIDTH bits wide and saturate;
// the outputs show the low 32 bits. After reset all counts are zero and the lexer is in
// normal text.
`include "assert_macros.svh"

module c_source_char_metrics_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_char_code,
    input  logic [9:0]  s_id_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_total_chars,
    output logic [31:0] m_comment_chars,
    output logic [31:0] m_space_chars,
    output logic [31:0] m_line_comments,
    output logic [31:0] m_block_comments,
    output logic [31:0] m_lines,
    output logic [15:0] m_max_line_len,
    output logic [31:0] m_strings
);

    localparam int IW = cslm_pkg::ID_LEN_WIDTH;
    localparam int LW = cslm_pkg::LINE_LEN_WIDTH;
    localparam int OW = cslm_pkg::OUT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    function automatic cnt_t sat_add(input cnt_t v, input logic [IW-1:0] n);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, v} + {{(COUNT_WIDTH + 1 - IW){1'b0}}, n};
        return s[COUNT_WIDTH] ? CNT_MAX : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [OW-1:0] to_out(input cnt_t v);
        logic [COUNT_WIDTH+OW-1:0] ext;
        ext = {{OW{1'b0}}, v};
        return ext[OW-1:0];
    endfunction

    logic                 in_valid_reg;
    logic                 cmd_reg;
    logic [7:0]           char_reg;
    logic [IW-1:0]        id_len_reg;
    logic                 out_valid_reg;
    logic                 advance;

    cslm_pkg::lex_state_t lex_reg, lex_next, lex_step;
    cslm_pkg::lex_flags_t flags_raw, flags;

    cnt_t chars_reg, chars_next;
    cnt_t cmt_reg, cmt_next;
    cnt_t space_reg, space_next;
    cnt_t lcmt_reg, lcmt_next;
    cnt_t bcmt_reg, bcmt_next;
    cnt_t lines_reg, lines_next;
    cnt_t str_reg, str_next;

    logic [LW-1:0] line_len_reg, line_len_next;
    logic [LW-1:0] longest_reg, longest_next;
    logic [LW:0]   line_sum;
    logic [IW-1:0] step_len;
    logic          is_char, is_nl;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg    <= s_command;
            char_reg   <= s_char_code;
            id_len_reg <= s_id_length;
        end
    end

    cslm_lexer u_lexer (
        .state      (lex_reg),
        .char_code  (char_reg),
        .state_next (lex_step),
        .flags      (flags_raw)
    );

    always_comb begin
        is_char  = (cmd_reg == cslm_pkg::CMD_CHAR);
        is_nl    = is_char && (char_reg == cslm_pkg::CH_NL);
        step_len = is_char ? IW'(1) : id_len_reg;
        flags    = is_char ? flags_raw : '0;
        lex_next = is_char ? lex_step : lex_reg;

        line_sum      = {1'b0, line_len_reg} + {{(LW + 1 - IW){1'b0}}, step_len};
        line_len_next = is_nl ? '0 : (line_sum[LW] ? '1 : line_sum[LW-1:0]);
        longest_next  = (is_nl && (line_len_reg > longest_reg)) ? line_len_reg : longest_reg;

        chars_next = sat_add(chars_reg, step_len);
        lines_next = sat_add(lines_reg, {{(IW - 1){1'b0}}, is_nl});
        space_next = sat_add(space_reg, {{(IW - 1){1'b0}}, flags.space_inc});
        str_next   = sat_add(str_reg, {{(IW - 1){1'b0}}, flags.string_inc});
        lcmt_next  = sat_add(lcmt_reg, {{(IW - 1){1'b0}}, flags.line_cmt_inc});
        bcmt_next  = sat_add(bcmt_reg, {{(IW - 1){1'b0}}, flags.block_cmt_inc});
        if (flags.cmt_char_dec) begin
            cmt_next = ((cmt_reg != '0) && (cmt_reg != CNT_MAX)) ? cmt_reg - cnt_t'(1) : cmt_reg;
        end else begin
            cmt_next = sat_add(cmt_reg, {{(IW - 1){1'b0}}, flags.cmt_char_inc});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            lex_reg       <= cslm_pkg::LEX_NORMAL;
            line_len_reg  <= '0;
            longest_reg   <= '0;
            chars_reg     <= '0;
            cmt_reg       <= '0;
            space_reg     <= '0;
            lcmt_reg      <= '0;
            bcmt_reg      <= '0;
            lines_reg     <= '0;
            str_reg       <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                lex_reg       <= lex_next;
                line_len_reg  <= line_len_next;
                longest_reg   <= longest_next;
                chars_reg     <= chars_next;
                cmt_reg       <= cmt_next;
                space_reg     <= space_next;
                lcmt_reg      <= lcmt_next;
                bcmt_reg      <= bcmt_next;
                lines_reg     <= lines_next;
                str_reg       <= str_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_total_chars    = to_out(chars_reg);
    assign m_comment_chars  = to_out(cmt_reg);
    assign m_space_chars    = to_out(space_reg);
    assign m_line_comments  = to_out(lcmt_reg);
    assign m_block_comments = to_out(bcmt_reg);
    assign m_lines          = to_out(lines_reg);
    assign m_max_line_len   = longest_reg;
    assign m_strings        = to_out(str_reg);

    `ASSERT_CLK(a_stall_only_on_full, aclk, aresetn, !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready), "input stalled without a blocked result")
    `ASSERT_CLK(a_advance_gives_result, aclk, aresetn, advance |=> m_valid, "transfer advanced but no result presented")
    `ASSERT_CLK(a_lines_only_on_newline, aclk, aresetn, (advance && !is_nl) |=> (lines_reg == $past(lines_reg)), "line count moved without a newline")
    `ASSERT_NEVER(a_cmt_inc_and_dec, aclk, aresetn, flags.cmt_char_inc && flags.cmt_char_dec, "comment count raised and dropped together")

endmodule

[dv/tb.sv]
// Self-checking testbench for c_source_char_metrics_core: a directed table, then C-like text.
// Depends on cslm_pkg and the core RTL; predicts every result transfer in SystemVerilog.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 410;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic [31:0] total_chars;
        logic [31:0] comment_chars;
        logic [31:0] space_chars;
        logic [31:0] line_comments;
        logic [31:0] block_comments;
        logic [31:0] lines;
        logic [15:0] max_line_len;
        logic [31:0] strings;
    } metrics_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic [9:0] id_len;
        logic       known;
        metrics_t   known_m;
    } item_t;

    localparam metrics_t NO_REF = '0;

    localparam item_t DIRECTED_ROWS [27] = '{
        '{cslm_pkg::CMD_CHAR,  8'h61, 10'h3FF, 1'b1,
          '{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0}},
        '{cslm_pkg::CMD_IDENT, 8'hFF, 10'h3FF, 1'b1,
          '{32'd1024, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0}},
        '{cslm_pkg::CMD_IDENT, 8'h00, 10'h000, 1'b1,
          '{32'd1024, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0}},
        '{cslm_pkg::CMD_CHAR,  8'hFF, 10'h000, 1'b1,
          '{32'd1025, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0}},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_NL, 10'h000, 1'b1,
          '{32'd1026, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1, 16'd1025, 32'd0}},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_SPACE,  10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_TAB,    10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  CH_VT,               10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_CR,     10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_DQUOTE, 10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_BSLASH, 10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_DQUOTE, 10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_DQUOTE, 10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_QUOTE,  10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_BSLASH, 10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_QUOTE,  10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_QUOTE,  10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_SLASH,  10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_SLASH,  10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_IDENT, 8'h00,               10'd5, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_NL,     10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_SLASH,  10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_STAR,   10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_STAR,   10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  8'h78,               10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_STAR,   10'd0, 1'b0, NO_REF},
        '{cslm_pkg::CMD_CHAR,  cslm_pkg::CH_SLASH,  10'd0, 1'b0, NO_REF}
    };

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_command   = 1'b0;
    logic [7:0]  s_char_code = 8'h00;
    logic [9:0]  s_id_length = 10'h000;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [31:0] m_total_chars;
    logic [31:0] m_comment_chars;
    logic [31:0] m_space_chars;
    logic [31:0] m_line_comments;
    logic [31:0] m_block_comments;
    logic [31:0] m_lines;
    logic [15:0] m_max_line_len;
    logic [31:0] m_strings;

    c_source_char_metrics_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_char_code      (s_char_code),
        .s_id_length      (s_id_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_total_chars    (m_total_chars),
        .m_comment_chars  (m_comment_chars),
        .m_space_chars    (m_space_chars),
        .m_line_comments  (m_line_comments),
        .m_block_comments (m_block_comments),
        .m_lines          (m_lines),
        .m_max_line_len   (m_max_line_len),
        .m_strings        (m_strings)
    );

    always #6 aclk = ~aclk;

    // predicted lexer and counter state
    cslm_pkg::lex_state_t lex_st = cslm_pkg::LEX_NORMAL;
    logic [15:0] cur_len     = '0;
    logic [15:0] longest     = '0;
    logic [31:0] n_chars     = '0;
    logic [31:0] n_cmt_chars = '0;
    logic [31:0] n_spaces    = '0;
    logic [31:0] n_line_cmts = '0;
    logic [31:0] n_blk_cmts  = '0;
    logic [31:0] n_lines     = '0;
    logic [31:0] n_strings   = '0;

    metrics_t metrics_due[$];
    item_t    text_items[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_start    = 1'b0;
    logic hold_on      = 1'b0;
    int  mismatches    = 0;
    int  n_sent        = 0;
    int  n_checked     = 0;

    function automatic logic [31:0] sat32(input logic [31:0] v, input logic [31:0] n);
        logic [32:0] s;
        s = {1'b0, v} + {1'b0, n};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] v, input logic [15:0] n);
        logic [16:0] s;
        s = {1'b0, v} + {1'b0, n};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic metrics_t step_metrics(input logic cmd, input logic [7:0] ch,
                                              input logic [9:0] id_len);
        metrics_t m;
        if (cmd == cslm_pkg::CMD_IDENT) begin
            n_chars = sat32(n_chars, 32'(id_len));
            cur_len = sat16(cur_len, 16'(id_len));
        end else begin
            n_chars = sat32(n_chars, 32'd1);
            if (ch == cslm_pkg::CH_NL) begin
                n_lines = sat32(n_lines, 32'd1);
                if (cur_len > longest) longest = cur_len;
                cur_len = '0;
            end else begin
                cur_len = sat16(cur_len, 16'd1);
            end
            case (lex_st)
                cslm_pkg::LEX_CHAR: begin
                    if (ch == cslm_pkg::CH_QUOTE) lex_st = cslm_pkg::LEX_NORMAL;
                    else if (ch == cslm_pkg::CH_BSLASH) lex_st = cslm_pkg::LEX_CHR_ESC;
                end
                cslm_pkg::LEX_STRING: begin
                    if (ch == cslm_pkg::CH_DQUOTE) lex_st = cslm_pkg::LEX_NORMAL;
                    else if (ch == cslm_pkg::CH_BSLASH) lex_st = cslm_pkg::LEX_STR_ESC;
                end
                cslm_pkg::LEX_CHR_ESC: lex_st = cslm_pkg::LEX_CHAR;
                cslm_pkg::LEX_STR_ESC: lex_st = cslm_pkg::LEX_STRING;
                cslm_pkg::LEX_SLASH: begin
                    if (ch == cslm_pkg::CH_SLASH) begin
                        lex_st = cslm_pkg::LEX_LINE_CMT;
                        n_line_cmts = sat32(n_line_cmts, 32'd1);
                    end else if (ch == cslm_pkg::CH_STAR) begin
                        lex_st = cslm_pkg::LEX_BLOCK_CMT;
                        n_blk_cmts = sat32(n_blk_cmts, 32'd1);
                    end else begin
                        lex_st = cslm_pkg::LEX_NORMAL;
                    end
                end
                cslm_pkg::LEX_LINE_CMT: begin
                    if (ch == cslm_pkg::CH_NL) lex_st = cslm_pkg::LEX_NORMAL;
                    else n_cmt_chars = sat32(n_cmt_chars, 32'd1);
                end
                cslm_pkg::LEX_BLOCK_CMT: begin
                    if (ch == cslm_pkg::CH_STAR) lex_st = cslm_pkg::LEX_BLOCK_STAR;
                    n_cmt_chars = sat32(n_cmt_chars, 32'd1);
                end
                cslm_pkg::LEX_BLOCK_STAR: begin
                    if (ch == cslm_pkg::CH_SLASH) begin
                        lex_st = cslm_pkg::LEX_NORMAL;
                        if (n_cmt_chars != '0 && n_cmt_chars != 32'hFFFF_FFFF)
                            n_cmt_chars = n_cmt_chars - 32'd1;
                    end else begin
                        if (ch != cslm_pkg::CH_STAR) lex_st = cslm_pkg::LEX_BLOCK_CMT;
                        n_cmt_chars = sat32(n_cmt_chars, 32'd1);
                    end
                end
                default: begin
                    lex_st = cslm_pkg::LEX_NORMAL;
                    if (ch == cslm_pkg::CH_SPACE ||
                        (ch >= cslm_pkg::CH_TAB && ch <= cslm_pkg::CH_CR)) begin
                        n_spaces = sat32(n_spaces, 32'd1);
                    end else if (ch == cslm_pkg::CH_SLASH) begin
                        lex_st = cslm_pkg::LEX_SLASH;
                    end else if (ch == cslm_pkg::CH_QUOTE) begin
                        lex_st = cslm_pkg::LEX_CHAR;
                    end else if (ch == cslm_pkg::CH_DQUOTE) begin
                        lex_st = cslm_pkg::LEX_STRING;
                        n_strings = sat32(n_strings, 32'd1);
                    end
                end
            endcase
        end
        m.total_chars    = n_chars;
        m.comment_chars  = n_cmt_chars;
        m.space_chars    = n_spaces;
        m.line_comments  = n_line_cmts;
        m.block_comments = n_blk_cmts;
        m.lines          = n_lines;
        m.max_line_len   = longest;
        m.strings        = n_strings;
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     n_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic check_result();
        metrics_t want;
        if (metrics_due.size() == 0) begin
            report_mismatch("unexpected result transfer", m_total_chars, '0);
        end else begin
            want = metrics_due.pop_front();
            check_field("total_chars", m_total_chars, want.total_chars);
            check_field("comment_chars", m_comment_chars, want.comment_chars);
            check_field("space_chars", m_space_chars, want.space_chars);
            check_field("line_comments", m_line_comments, want.line_comments);
            check_field("block_comments", m_block_comments, want.block_comments);
            check_field("lines", m_lines, want.lines);
            check_field("max_line_len", 32'(m_max_line_len), 32'(want.max_line_len));
            check_field("strings", m_strings, want.strings);
        end
        n_checked++;
    endtask

    // result side: check on transfer, then pick the next ready
    initial begin : result_side
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_result();
            m_ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : recv_hold
        wait (hold_start);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("timeout with %0d results outstanding", metrics_due.size());
        $display("** c_source_char_metrics_core: FAILED **");
        $finish;
    end

    task automatic put_char(input logic [7:0] ch);
        item_t it;
        it = '0;
        it.cmd    = cslm_pkg::CMD_CHAR;
        it.ch     = ch;
        it.id_len = 10'($urandom_range(1023));
        text_items.push_back(it);
    endtask

    task automatic put_ident(input logic [9:0] id_len);
        item_t it;
        it = '0;
        it.cmd    = cslm_pkg::CMD_IDENT;
        it.ch     = 8'($urandom_range(255));
        it.id_len = id_len;
        text_items.push_back(it);
    endtask

    function automatic logic [9:0] ident_len();
        return ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(1, 16));
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == cslm_pkg::CH_DQUOTE || c == cslm_pkg::CH_QUOTE ||
               c == cslm_pkg::CH_BSLASH || c == cslm_pkg::CH_SLASH ||
               c == cslm_pkg::CH_STAR);
        return c;
    endfunction

    // any byte but the comment delimiters and newline
    function automatic logic [7:0] body_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c == cslm_pkg::CH_STAR || c == cslm_pkg::CH_SLASH || c == cslm_pkg::CH_NL);
        return c;
    endfunction

    task automatic add_token();
        int r;
        int k;
        int n;
        r = $urandom_range(99);
        if (r < 25) begin
            put_ident(ident_len());
        end else if (r < 40) begin
            case ($urandom_range(4))
                0: put_char(cslm_pkg::CH_SPACE);
                1: put_char(cslm_pkg::CH_TAB);
                2: put_char(CH_VT);
                3: put_char(CH_FF);
                default: put_char(cslm_pkg::CH_CR);
            endcase
        end else if (r < 48) begin
            put_char(cslm_pkg::CH_NL);
        end else if (r < 56) begin
            put_char(cslm_pkg::CH_DQUOTE);
            n = $urandom_range(0, 8);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(5) == 0) begin
                    put_char(cslm_pkg::CH_BSLASH);
                    put_char(8'($urandom_range(255)));
                end else begin
                    put_char(($urandom_range(3) == 0) ? cslm_pkg::CH_SPACE : plain_byte());
                end
            end
            put_char(cslm_pkg::CH_DQUOTE);
        end else if (r < 62) begin
            put_char(cslm_pkg::CH_QUOTE);
            if ($urandom_range(2) == 0) put_char(cslm_pkg::CH_BSLASH);
            put_char(8'($urandom_range(255)));
            put_char(cslm_pkg::CH_QUOTE);
        end else if (r < 70) begin
            put_char(cslm_pkg::CH_SLASH);
            put_char(cslm_pkg::CH_SLASH);
            n = $urandom_range(0, 10);
            for (k = 0; k < n; k++) begin
                case ($urandom_range(5))
                    0: put_ident(ident_len());
                    1: put_char(cslm_pkg::CH_STAR);
                    2: put_char(cslm_pkg::CH_SLASH);
                    default: put_char(body_byte());
                endcase
            end
            put_char(cslm_pkg::CH_NL);
        end else if (r < 80) begin
            put_char(cslm_pkg::CH_SLASH);
            put_char(cslm_pkg::CH_STAR);
            n = $urandom_range(0, 12);
            for (k = 0; k < n; k++) begin
                case ($urandom_range(7))
                    0: begin
                        repeat ($urandom_range(1, 3)) put_char(cslm_pkg::CH_STAR);
                        put_char(body_byte());
                    end
                    1: put_char(cslm_pkg::CH_SLASH);
                    2: put_ident(ident_len());
                    3: put_char(cslm_pkg::CH_NL);
                    default: put_char(body_byte());
                endcase
            end
            repeat ($urandom_range(1, 3)) put_char(cslm_pkg::CH_STAR);
            put_char(cslm_pkg::CH_SLASH);
        end else if (r < 90) begin
            if ($urandom_range(1) == 0) begin
                put_char(cslm_pkg::CH_SLASH);
                put_char(plain_byte());
            end else begin
                put_char(plain_byte());
            end
        end else begin
            // noise: raw bytes, stray delimiters, unterminated literals
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                case ($urandom_range(6))
                    0: put_char(cslm_pkg::CH_DQUOTE);
                    1: put_char(cslm_pkg::CH_QUOTE);
                    2: put_char(cslm_pkg::CH_SLASH);
                    3: put_char(cslm_pkg::CH_STAR);
                    4: put_ident(10'($urandom_range(1023)));
                    default: put_char(8'($urandom_range(255)));
                endcase
            end
        end
    endtask

    task automatic send_item(input item_t it);
        metrics_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= it.cmd;
        s_char_code <= it.ch;
        s_id_length <= it.id_len;
        do @(posedge aclk); while (!s_ready);
        want = step_metrics(it.cmd, it.ch, it.id_len);
        metrics_due.push_back(it.known ? it.known_m : want);
        n_sent++;
    endtask

    task automatic send_queued();
        while (text_items.size() != 0) send_item(text_items.pop_front());
    endtask

    task automatic await_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (metrics_due.size() != 0);
    endtask

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 22;
        recv_idle_pct = 68;
        foreach (DIRECTED_ROWS[i]) send_item(DIRECTED_ROWS[i]);
        await_results();

        // saturate the line length once, then random text
        repeat (70) put_ident(10'h3FF);
        put_char(cslm_pkg::CH_NL);
        while (text_items.size() < PHASE_ITEMS) add_token();
        send_queued();
        await_results();

        send_idle_pct = 68;
        recv_idle_pct = 22;
        while (text_items.size() < PHASE_ITEMS) add_token();
        send_queued();
        await_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_start = 1'b1;
        while (text_items.size() < PHASE_ITEMS) add_token();
        send_queued();
        await_results();
        repeat (8) @(posedge aclk);

        $display("%0d items sent (%0d from the table), %0d results checked, %0d mismatches",
                 n_sent, $size(DIRECTED_ROWS), n_checked, mismatches);
        $display("final counts: %0d chars, %0d lines (longest %0d), %0d/%0d comments, %0d strings",
                 n_chars, n_lines, longest, n_line_cmts, n_blk_cmts, n_strings);
        if (mismatches == 0) begin
            $display("** c_source_char_metrics_core: PASSED **");
        end else begin
            $display("** c_source_char_metrics_core: FAILED **");
        end
        $finish;
    end

endmodule
